// File: rtl/aarm_pkg.sv
package aarm_pkg;

    // field width on every channel
    localparam int IO_W = 16;

    // square root of the squared norm shifted up by 32: one result bit per step
    localparam int ISQRT_STAGES = 32;

    // angle handling in Q30
    localparam int      ANGLE_SHIFT = 17;
    localparam longint  Q30_PI      = 64'd3373259426;
    localparam longint  Q30_HALF_PI = 64'd1686629713;
    localparam longint  Q30_GAIN    = 64'd652032874;

    typedef logic signed [IO_W-1:0] word_t;

    typedef logic [31:0] atan_tab_t [0:31];

    // arctangent of 2^-i in Q30
    localparam atan_tab_t ATAN_Q30 = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

endpackage

// File: rtl/aarm_in_if.sv
interface aarm_in_if;
    import aarm_pkg::*;

    logic  valid;
    logic  ready;
    word_t angle_rad;
    word_t axis_x;
    word_t axis_y;
    word_t axis_z;

    modport source (output valid, output angle_rad, output axis_x, output axis_y,
                    output axis_z, input ready);
    modport sink   (input valid, input angle_rad, input axis_x, input axis_y,
                    input axis_z, output ready);
endinterface

// File: rtl/aarm_out_if.sv
interface aarm_out_if;
    import aarm_pkg::*;

    logic  valid;
    logic  ready;
    word_t elem0;
    word_t elem1;
    word_t elem2;
    word_t elem4;
    word_t elem5;
    word_t elem6;
    word_t elem8;
    word_t elem9;
    word_t elem10;
    logic  zero_axis;

    modport source (output valid, output elem0, output elem1, output elem2,
                    output elem4, output elem5, output elem6, output elem8,
                    output elem9, output elem10, output zero_axis, input ready);
    modport sink   (input valid, input elem0, input elem1, input elem2,
                    input elem4, input elem5, input elem6, input elem8,
                    input elem9, input elem10, input zero_axis, output ready);
endinterface

// File: rtl/aarm_delay.sv
module aarm_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    // plain shift line, advances with the pipeline
    logic [W-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];
endmodule

// File: rtl/aarm_isqrt.sv
module aarm_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] n2,
    output logic [31:0] root
);
    import aarm_pkg::*;

    localparam int REMW = 36;

    logic [REMW-1:0] rem_reg  [0:ISQRT_STAGES-1];
    logic [31:0]     root_reg [0:ISQRT_STAGES-1];
    logic [63:0]     rad_reg  [0:ISQRT_STAGES-1];

    // restoring square root, two radicand bits per stage
    for (genvar j = 0; j < ISQRT_STAGES; j++)
    begin : g_step
        logic [REMW-1:0] rem_in;
        logic [31:0]     root_in;
        logic [63:0]     rad_in;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {n2, 32'd0};
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rad_in  = rad_reg[j-1];
        end

        assign rem_sh = {rem_in[REMW-3:0], rad_in[63:62]};
        assign trial  = REMW'({root_in, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[j] <= {rad_in[61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg[j]  <= rem_sh - trial;
                    root_reg[j] <= {root_in[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[j]  <= rem_sh;
                    root_reg[j] <= {root_in[30:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[ISQRT_STAGES-1];
endmodule

// File: rtl/aarm_div.sv
module aarm_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [15:0]                   mag,
    input  logic                          neg,
    input  logic [31:0]                   rdiv,
    output logic signed [FRAC_BITS+2:0]   unit
);
    localparam int QB = FRAC_BITS + 1;
    localparam int NW = FRAC_BITS + 32;
    localparam int W  = FRAC_BITS + 3;
    localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

    logic [31:0]    rem_reg [0:QB-1];
    logic [QB-1:0]  low_reg [0:QB-1];
    logic [QB-1:0]  quo_reg [0:QB-1];
    logic [31:0]    div_reg [0:QB-1];
    logic           neg_reg [0:QB-1];
    logic signed [W-1:0] unit_reg;

    // rounded numerator: magnitude scaled up plus half the divisor
    logic [NW-1:0] num;
    assign num = {mag, {(FRAC_BITS+16){1'b0}}} + NW'(rdiv >> 1);

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [31:0]   rem_in;
        logic [QB-1:0] low_in;
        logic [QB-1:0] quo_in;
        logic [31:0]   div_in;
        logic          neg_in;
        logic [32:0]   rem_sh;

        if (k == 0)
        begin : g_first
            assign rem_in = 32'(num[NW-1:QB]);
            assign low_in = num[QB-1:0];
            assign quo_in = '0;
            assign div_in = rdiv;
            assign neg_in = neg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign div_in = div_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign rem_sh = {rem_in, low_in[QB-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                low_reg[k] <= {low_in[QB-2:0], 1'b0};
                div_reg[k] <= div_in;
                neg_reg[k] <= neg_in;
                if (rem_sh >= {1'b0, div_in})
                begin
                    rem_reg[k] <= 32'(rem_sh - {1'b0, div_in});
                    quo_reg[k] <= {quo_in[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= rem_sh[31:0];
                    quo_reg[k] <= {quo_in[QB-2:0], 1'b0};
                end
            end
        end
    end

    // cap at one and restore the sign
    logic [QB-1:0]       quo_cap;
    logic signed [W-1:0] quo_s;
    assign quo_cap = (quo_reg[QB-1] > ONE_Q) ? ONE_Q : quo_reg[QB-1];
    assign quo_s   = $signed(W'(quo_cap));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= neg_reg[QB-1] ? -quo_s : quo_s;
        end
    end

    assign unit = unit_reg;
endmodule

// File: rtl/aarm_cordic.sv
module aarm_cordic #(
    parameter int FRAC_BITS     = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  aarm_pkg::word_t              angle,
    output logic signed [FRAC_BITS+2:0]  sn,
    output logic signed [FRAC_BITS+2:0]  omc
);
    import aarm_pkg::*;

    localparam int CS = CORDIC_STAGES;
    localparam int ZW = 35;
    localparam int XW = 33;
    localparam int W  = FRAC_BITS + 3;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [ZW-1:0] PI_Z   = ZW'(Q30_PI);
    localparam logic signed [ZW-1:0] HPI_Z  = ZW'(Q30_HALF_PI);
    localparam logic signed [XW-1:0] GAIN_X = XW'(Q30_GAIN);
    localparam logic signed [W-1:0]  ONE_W  = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};

    logic signed [XW-1:0] x_reg    [0:CS];
    logic signed [XW-1:0] y_reg    [0:CS];
    logic signed [ZW-1:0] z_reg    [0:CS];
    logic                 flip_reg [0:CS];
    logic signed [W-1:0]  sn_reg;
    logic signed [W-1:0]  omc_reg;

    // angle to Q30 and fold into half a turn
    logic signed [ZW-1:0] z_in;
    assign z_in = {{(ZW-IO_W-ANGLE_SHIFT){angle[IO_W-1]}}, angle, {ANGLE_SHIFT{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN_X;
            y_reg[0] <= '0;
            if (z_in > HPI_Z)
            begin
                z_reg[0]    <= z_in - PI_Z;
                flip_reg[0] <= 1'b1;
            end
            else if (z_in < -HPI_Z)
            begin
                z_reg[0]    <= z_in + PI_Z;
                flip_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0]    <= z_in;
                flip_reg[0] <= 1'b0;
            end
        end
    end

    // rotation stages
    for (genvar i = 0; i < CS; i++)
    begin : g_rot
        logic signed [ZW-1:0] at;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        assign at = $signed({{(ZW-32){1'b0}}, ATAN_Q30[i]});
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
            end
        end
    end

    // undo the fold, round to the output format
    logic signed [XW:0]  xf;
    logic signed [XW:0]  yf;
    logic signed [XW:0]  xq;
    logic signed [XW:0]  yq;
    logic signed [W-1:0] cs_w;

    assign xf = flip_reg[CS] ? -(XW+1)'(x_reg[CS]) : (XW+1)'(x_reg[CS]);
    assign yf = flip_reg[CS] ? -(XW+1)'(y_reg[CS]) : (XW+1)'(y_reg[CS]);

    if (SH > 0)
    begin : g_rnd
        localparam logic signed [XW:0] HALF = (XW+1)'(1) << (SH - 1);
        assign xq = (xf + HALF) >>> SH;
        assign yq = (yf + HALF) >>> SH;
    end
    else
    begin : g_exact
        assign xq = xf;
        assign yq = yf;
    end

    assign cs_w = W'(xq);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_reg  <= W'(yq);
            omc_reg <= ONE_W - cs_w;
        end
    end

    assign sn  = sn_reg;
    assign omc = omc_reg;
endmodule

// File: rtl/aarm_mat.sv
module aarm_mat #(
    parameter int FRAC_BITS = 14
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [FRAC_BITS+2:0]  vx,
    input  logic signed [FRAC_BITS+2:0]  vy,
    input  logic signed [FRAC_BITS+2:0]  vz,
    input  logic signed [FRAC_BITS+2:0]  sn,
    input  logic signed [FRAC_BITS+2:0]  omc,
    input  logic                         zero,
    output aarm_pkg::word_t              elem [0:8],
    output logic                         zero_axis
);
    import aarm_pkg::*;

    localparam int W  = FRAC_BITS + 3;
    localparam int EW = (W + 1 > IO_W) ? W + 1 : IO_W;
    localparam logic signed [2*W-1:0] HALF_P = (2*W)'(1) << (FRAC_BITS - 1);
    localparam logic signed [W-1:0]   ONE_W  = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [W:0]     ONE_S  = {3'b000, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [W:0]     NEG_S  = -ONE_S;

    // product rounded half up back to the fraction format
    function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = a * b;
        p = p + HALF_P;
        return W'(p >>> FRAC_BITS);
    endfunction

    // clamp to plus or minus one, keep the low field bits
    function automatic word_t sat16(input logic signed [W:0] v);
        logic signed [W:0]    c;
        logic signed [EW-1:0] t;
        if (v > ONE_S)
            c = ONE_S;
        else if (v < NEG_S)
            c = NEG_S;
        else
            c = v;
        t = EW'(c);
        return t[IO_W-1:0];
    endfunction

    // first products
    logic signed [W-1:0] xx_reg, yy_reg, zz_reg, cx_reg, cy_reg;
    logic signed [W-1:0] xs1_reg, ys1_reg, zs1_reg, c1_reg, vy1_reg, vz1_reg;
    logic                zero1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg    <= qmul(vx, vx);
            yy_reg    <= qmul(vy, vy);
            zz_reg    <= qmul(vz, vz);
            cx_reg    <= qmul(omc, vx);
            cy_reg    <= qmul(omc, vy);
            xs1_reg   <= qmul(vx, sn);
            ys1_reg   <= qmul(vy, sn);
            zs1_reg   <= qmul(vz, sn);
            c1_reg    <= omc;
            vy1_reg   <= vy;
            vz1_reg   <= vz;
            zero1_reg <= zero;
        end
    end

    // second products
    logic signed [W-1:0] d0_reg, d5_reg, d10_reg, pxy_reg, pxz_reg, pyz_reg;
    logic signed [W-1:0] xs2_reg, ys2_reg, zs2_reg;
    logic                zero2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg    <= qmul(c1_reg, xx_reg - ONE_W);
            d5_reg    <= qmul(c1_reg, yy_reg - ONE_W);
            d10_reg   <= qmul(c1_reg, zz_reg - ONE_W);
            pxy_reg   <= qmul(cx_reg, vy1_reg);
            pxz_reg   <= qmul(cx_reg, vz1_reg);
            pyz_reg   <= qmul(cy_reg, vz1_reg);
            xs2_reg   <= xs1_reg;
            ys2_reg   <= ys1_reg;
            zs2_reg   <= zs1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // sums, saturation, identity for a zero-length axis
    logic signed [W:0] e_sum [0:8];
    word_t             elem_reg [0:8];
    logic              zero_reg;

    always_comb
    begin
        e_sum[0] = ONE_S + (W+1)'(d0_reg);
        e_sum[1] = (W+1)'(pxy_reg) + (W+1)'(zs2_reg);
        e_sum[2] = (W+1)'(pxz_reg) - (W+1)'(ys2_reg);
        e_sum[3] = (W+1)'(pxy_reg) - (W+1)'(zs2_reg);
        e_sum[4] = ONE_S + (W+1)'(d5_reg);
        e_sum[5] = (W+1)'(pyz_reg) + (W+1)'(xs2_reg);
        e_sum[6] = (W+1)'(pxz_reg) + (W+1)'(ys2_reg);
        e_sum[7] = (W+1)'(pyz_reg) - (W+1)'(xs2_reg);
        e_sum[8] = ONE_S + (W+1)'(d10_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= zero2_reg;
            for (int i = 0; i < 9; i++)
            begin
                if (zero2_reg)
                    elem_reg[i] <= (i == 0 || i == 4 || i == 8) ? sat16(ONE_S) : '0;
                else
                    elem_reg[i] <= sat16(e_sum[i]);
            end
        end
    end

    assign elem      = elem_reg;
    assign zero_axis = zero_reg;
endmodule

// File: rtl/axis_angle_rotation_matrix_unit.sv
// Axis-angle to rotation matrix (Rodrigues), fixed point.
// cmd channel: angle_rad (Q2.13 radians) and an axis (axis_x/y/z, Q1.14) of
// any non-zero length. res channel: the nine entries of the 3x3 rotation part
// of a 4x4 matrix, named by their flat index, saturated to +/-1, and the
// zero_axis flag; a zero-length axis gives the identity with zero_axis set.
// The axis path sets the delay from cmd transfer to res valid: the squares
// and the squared norm registers, 32 square root steps, FRAC_BITS + 1
// quotient steps plus a sign stage, three matrix stages. The CORDIC unit
// runs alongside and is delayed to match.
// Throughput: one transfer per cycle in each direction, back to back, while res.ready stays high.
// Every stage advances together; while res is valid and not ready the whole
// pipeline holds and cmd.ready is low, so nothing is lost or repeated.
// Reset clears the valid bits only; the pipeline comes out empty.
module axis_angle_rotation_matrix_unit #(
    parameter int FRAC_BITS     = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    aarm_in_if.sink           cmd,
    aarm_out_if.source        res
);
    import aarm_pkg::*;

    localparam int W      = FRAC_BITS + 3;
    localparam int QB     = FRAC_BITS + 1;
    localparam int L_UNIT = 2 + ISQRT_STAGES + QB + 1;
    localparam int L_COR  = CORDIC_STAGES + 2;
    localparam int LAT    = L_UNIT + 3;

    logic en;
    logic [LAT-1:0] vld_reg;

    // global advance: the pipeline moves unless a result is held
    assign en        = !vld_reg[LAT-1] || res.ready;
    assign cmd.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], cmd.valid};
    end

    // squares and magnitudes
    logic signed [31:0] sqx_reg, sqy_reg, sqz_reg;
    logic [15:0]        magx_reg, magy_reg, magz_reg;
    logic               negx_reg, negy_reg, negz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg  <= cmd.axis_x * cmd.axis_x;
            sqy_reg  <= cmd.axis_y * cmd.axis_y;
            sqz_reg  <= cmd.axis_z * cmd.axis_z;
            magx_reg <= cmd.axis_x[IO_W-1] ? 16'(-cmd.axis_x) : 16'(cmd.axis_x);
            magy_reg <= cmd.axis_y[IO_W-1] ? 16'(-cmd.axis_y) : 16'(cmd.axis_y);
            magz_reg <= cmd.axis_z[IO_W-1] ? 16'(-cmd.axis_z) : 16'(cmd.axis_z);
            negx_reg <= cmd.axis_x[IO_W-1];
            negy_reg <= cmd.axis_y[IO_W-1];
            negz_reg <= cmd.axis_z[IO_W-1];
        end
    end

    // squared norm
    logic [31:0] n2_next;
    logic [31:0] n2_reg;
    logic        zero_reg;

    assign n2_next = $unsigned(sqx_reg) + $unsigned(sqy_reg) + $unsigned(sqz_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg   <= n2_next;
            zero_reg <= (n2_next == 32'd0);
        end
    end

    // norm
    logic [31:0] rnorm;

    aarm_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .n2   (n2_reg),
        .root (rnorm)
    );

    // components wait for the norm
    logic [50:0] comp_dly;

    aarm_delay #(.W(51), .DEPTH(1 + ISQRT_STAGES)) u_comp_dly (
        .clk  (clk),
        .en   (en),
        .din  ({negx_reg, magx_reg, negy_reg, magy_reg, negz_reg, magz_reg}),
        .dout (comp_dly)
    );

    // unit axis
    logic signed [W-1:0] vx, vy, vz;

    aarm_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk (clk), .en (en), .mag (comp_dly[49:34]), .neg (comp_dly[50]),
        .rdiv (rnorm), .unit (vx)
    );

    aarm_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk (clk), .en (en), .mag (comp_dly[32:17]), .neg (comp_dly[33]),
        .rdiv (rnorm), .unit (vy)
    );

    aarm_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .clk (clk), .en (en), .mag (comp_dly[15:0]), .neg (comp_dly[16]),
        .rdiv (rnorm), .unit (vz)
    );

    // zero flag follows the axis path
    logic zero_dly;

    aarm_delay #(.W(1), .DEPTH(L_UNIT - 2)) u_zero_dly (
        .clk  (clk),
        .en   (en),
        .din  (zero_reg),
        .dout (zero_dly)
    );

    // sine and one minus cosine
    logic signed [W-1:0] sn_c, omc_c;
    logic [2*W-1:0]      trig_dly;

    aarm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .clk   (clk),
        .en    (en),
        .angle (cmd.angle_rad),
        .sn    (sn_c),
        .omc   (omc_c)
    );

    aarm_delay #(.W(2*W), .DEPTH(L_UNIT - L_COR)) u_trig_dly (
        .clk  (clk),
        .en   (en),
        .din  ({sn_c, omc_c}),
        .dout (trig_dly)
    );

    // matrix entries
    word_t elem [0:8];
    logic  zflag;

    aarm_mat #(.FRAC_BITS(FRAC_BITS)) u_mat (
        .clk       (clk),
        .en        (en),
        .vx        (vx),
        .vy        (vy),
        .vz        (vz),
        .sn        ($signed(trig_dly[2*W-1:W])),
        .omc       ($signed(trig_dly[W-1:0])),
        .zero      (zero_dly),
        .elem      (elem),
        .zero_axis (zflag)
    );

    assign res.valid     = vld_reg[LAT-1];
    assign res.elem0     = elem[0];
    assign res.elem1     = elem[1];
    assign res.elem2     = elem[2];
    assign res.elem4     = elem[3];
    assign res.elem5     = elem[4];
    assign res.elem6     = elem[5];
    assign res.elem8     = elem[6];
    assign res.elem9     = elem[7];
    assign res.elem10    = elem[8];
    assign res.zero_axis = zflag;
endmodule

// File: rtl/aarm_chk.sv
module aarm_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input aarm_pkg::word_t elem0,
    input aarm_pkg::word_t elem1,
    input aarm_pkg::word_t elem2,
    input aarm_pkg::word_t elem4,
    input aarm_pkg::word_t elem6,
    input aarm_pkg::word_t elem8,
    input aarm_pkg::word_t elem9,
    input logic            zero_axis
);
    // a held result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // a held result keeps elem0, elem1 and zero_axis
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(elem0) && $stable(elem1) && $stable(zero_axis))
        else $error("result changed while stalled");

    // a draining receiver never blocks the sender
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled although output drains");

    // zero-length axis gives no off-diagonal terms
    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_axis |-> elem1 == '0 && elem2 == '0 && elem4 == '0 &&
        elem6 == '0 && elem8 == '0 && elem9 == '0)
        else $error("zero axis without identity");
endmodule

bind axis_angle_rotation_matrix_unit aarm_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .elem0     (res.elem0),
    .elem1     (res.elem1),
    .elem2     (res.elem2),
    .elem4     (res.elem4),
    .elem6     (res.elem6),
    .elem8     (res.elem8),
    .elem9     (res.elem9),
    .zero_axis (res.zero_axis)
);

// File: dv/axis_angle_rotation_matrix_unit_tb.sv
module axis_angle_rotation_matrix_unit_tb;
    import aarm_pkg::*;

    localparam int  FRAC_BITS     = 14;
    localparam int  CORDIC_STAGES = 16;
    localparam int  LATENCY       = FRAC_BITS + 39;
    localparam longint ONE        = longint'(1) << FRAC_BITS;

    typedef struct {
        word_t elem [9];
        logic  zero_axis;
    } rot_matrix_t;

    logic clk;
    logic rst_n;

    aarm_in_if  cmd ();
    aarm_out_if res ();

    axis_angle_rotation_matrix_unit #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    rot_matrix_t pending_matrices [$];
    int          error_count;
    bit          quiet;        // no idling on either side
    int          hold_cycles;  // receiver hold-off request
    string       elem_names [9] = '{"elem0", "elem1", "elem2", "elem4", "elem5",
                                    "elem6", "elem8", "elem9", "elem10"};

    always #2 clk = ~clk;

    // floor square root, one result bit per pair of input bits
    function automatic bit [63:0] root_floor(bit [63:0] n);
        bit [63:0] root;
        bit [63:0] probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic longint round_shift(longint v, int sh);
        if (sh == 0)
            return v;
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return round_shift(a * b, FRAC_BITS);
    endfunction

    // component over axis length, rounded, capped at one
    function automatic longint unit_component(longint a, bit [63:0] r);
        bit [63:0] mag;
        bit [63:0] q;
        mag = (a < 0) ? -a : a;
        q   = ((mag << (FRAC_BITS + 16)) + (r >> 1)) / r;
        if (q > ONE)
            q = ONE;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic word_t clamp_one(longint v);
        if (v > ONE)
            v = ONE;
        if (v < -ONE)
            v = -ONE;
        return word_t'(v[15:0]);
    endfunction

    function automatic rot_matrix_t rodrigues_matrix(word_t ang_in, word_t ax_in,
                                                    word_t ay_in, word_t az_in);
        rot_matrix_t m;
        longint ax, ay, az, vx, vy, vz, ang, x, y, dx, dy, sn, cs, c, cx, cy;
        longint e [9];
        bit [63:0] n2, r;
        bit        flip;
        ax  = ax_in;
        ay  = ay_in;
        az  = az_in;
        ang = ang_in;
        n2  = ax * ax + ay * ay + az * az;
        if (n2 == 0)
        begin
            foreach (m.elem[k])
                m.elem[k] = 0;
            m.elem[0]   = clamp_one(ONE);
            m.elem[4]   = clamp_one(ONE);
            m.elem[8]   = clamp_one(ONE);
            m.zero_axis = 1'b1;
            return m;
        end
        r  = root_floor(n2 << 32);
        vx = unit_component(ax, r);
        vy = unit_component(ay, r);
        vz = unit_component(az, r);

        // fold the angle into -pi/2..pi/2
        ang  = ang <<< ANGLE_SHIFT;
        flip = 1'b0;
        if (ang > Q30_HALF_PI)
        begin
            ang  = ang - Q30_PI;
            flip = 1'b1;
        end
        else if (ang < -Q30_HALF_PI)
        begin
            ang  = ang + Q30_PI;
            flip = 1'b1;
        end
        x = Q30_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0)
            begin
                x   = x - dx;
                y   = y + dy;
                ang = ang - longint'(ATAN_Q30[i]);
            end
            else
            begin
                x   = x + dx;
                y   = y - dy;
                ang = ang + longint'(ATAN_Q30[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cs = round_shift(x, 30 - FRAC_BITS);
        sn = round_shift(y, 30 - FRAC_BITS);
        c  = ONE - cs;

        cx = fx_mul(c, vx);
        cy = fx_mul(c, vy);
        e[0] = ONE + fx_mul(c, fx_mul(vx, vx) - ONE);
        e[1] = fx_mul(cx, vy) + fx_mul(vz, sn);
        e[2] = fx_mul(cx, vz) - fx_mul(vy, sn);
        e[3] = fx_mul(cx, vy) - fx_mul(vz, sn);
        e[4] = ONE + fx_mul(c, fx_mul(vy, vy) - ONE);
        e[5] = fx_mul(cy, vz) + fx_mul(vx, sn);
        e[6] = fx_mul(cx, vz) + fx_mul(vy, sn);
        e[7] = fx_mul(cy, vz) - fx_mul(vx, sn);
        e[8] = ONE + fx_mul(c, fx_mul(vz, vz) - ONE);
        foreach (e[k])
            m.elem[k] = clamp_one(e[k]);
        m.zero_axis = 1'b0;
        return m;
    endfunction

    // one command transfer; valid stays high afterwards unless the next call idles
    task automatic send_rotation(word_t ang, word_t ax, word_t ay, word_t az);
        int gap;
        if (!quiet && $urandom_range(99) < 4)
        begin
            gap = $urandom_range(4, 1);
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.angle_rad <= ang;
        cmd.axis_x    <= ax;
        cmd.axis_y    <= ay;
        cmd.axis_z    <= az;
        do
            @(posedge clk);
        while (!cmd.ready);
        pending_matrices.push_back(rodrigues_matrix(ang, ax, ay, az));
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res.ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            res.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 10);
    end

    // result check against the oldest prediction
    always @(posedge clk)
    begin
        rot_matrix_t want;
        word_t       got [9];
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.elem0, res.elem1, res.elem2, res.elem4, res.elem5,
                    res.elem6, res.elem8, res.elem9, res.elem10};
            if (pending_matrices.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual elem0 %0d", $time,
                         res.elem0);
                error_count++;
            end
            else
            begin
                want = pending_matrices.pop_front();
                foreach (got[k])
                    if (got[k] !== want.elem[k])
                    begin
                        $display("%0t: %s expected %0d actual %0d", $time,
                                 elem_names[k], want.elem[k], got[k]);
                        error_count++;
                    end
                if (res.zero_axis !== want.zero_axis)
                begin
                    $display("%0t: zero_axis expected %0b actual %0b", $time,
                             want.zero_axis, res.zero_axis);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        word_t axes [8][3] = '{
            '{16'sd16384, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, -16'sd1},
            '{-16'sd32768, 16'sd0, 16'sd0}, '{16'sd32767, 16'sd32767, 16'sd32767},
            '{-16'sd32768, -16'sd32768, -16'sd32768}, '{16'sd1, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd1, -16'sd1}, '{16'sd9459, -16'sd9459, 16'sd9459}};
        word_t angles [8] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
                              -16'sd12868, 16'sd32767, -16'sd32768, 16'sd1};
        // zero-length axis at several angles
        send_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_rotation(16'sd25736, 16'sd0, 16'sd0, 16'sd0);
        send_rotation(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
        foreach (axes[k])
            send_rotation(angles[k], axes[k][0], axes[k][1], axes[k][2]);
        foreach (axes[k])
            send_rotation(angles[7 - k], axes[k][0], axes[k][1], axes[k][2]);
        // around a right angle, fold boundary
        send_rotation(16'sd12867, 16'sd0, 16'sd16384, 16'sd0);
        send_rotation(-16'sd12867, 16'sd0, 16'sd16384, 16'sd0);
    endtask

    task automatic test_random(int count);
        word_t ang, ax, ay, az;
        int    kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(9);
            ang  = (kind < 4) ? word_t'($urandom) : word_t'($urandom_range(51472) - 25736);
            ax   = word_t'($urandom);
            ay   = word_t'($urandom);
            az   = word_t'($urandom);
            case (kind)
                0: {ax, ay, az} = '0;
                1: {ay, az} = '0;
                2: {ax, ay, az} = {word_t'($urandom_range(6) - 3),
                                   word_t'($urandom_range(6) - 3),
                                   word_t'($urandom_range(6) - 3)};
                default: ;
            endcase
            send_rotation(ang, ax, ay, az);
        end
    endtask

    // receiver holds off while commands keep coming, so the pipeline backs up
    task automatic test_backpressure();
        hold_cycles = 300;
        test_random(150);
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        test_random(200);
        quiet = 1'b0;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cmd.valid     = 1'b0;
        cmd.angle_rad = '0;
        cmd.axis_x    = '0;
        cmd.axis_y    = '0;
        cmd.axis_z    = '0;
        res.ready     = 1'b0;
        error_count   = 0;
        quiet         = 1'b0;
        hold_cycles   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(400);
        test_backpressure();
        test_back_to_back();
        test_random(400);
        cmd.valid <= 1'b0;

        wait (pending_matrices.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("[axis_angle_rotation_matrix_unit] OK");
        else
            $display("[axis_angle_rotation_matrix_unit] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("[axis_angle_rotation_matrix_unit] ERROR");
        $finish;
    end

endmodule
